[hdl/vtkq_pkg.sv]
package vtkq_pkg;

  localparam int VTS_DEF         = 8;
  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int MAX_READ_DEF    = 64;

  localparam int OP_W     = 2;
  localparam int TERM_W   = 4;
  localparam int KEY_W    = 8;
  localparam int LIMIT_W  = 7;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
  localparam logic [OP_W-1:0] OP_READ     = 2'd1;
  localparam logic [OP_W-1:0] OP_ACTIVATE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADTERM   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTACTIVE = 3'd5;

  localparam logic [KEY_W-1:0] KEY_NEWLINE = 8'h0A;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic finish;    // single result: commit push/activate, load result
    logic rd_issue;  // first key store read of a read operation
    logic pop;       // emit one popped byte
  } vtkq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_read;
    logic stop;
    logic out_free;
  } vtkq_sts_t;

endpackage

[hdl/vtkq_ifs.sv]
interface vtkq_in_if;
  import vtkq_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [TERM_W-1:0]   terminal;
  logic [KEY_W-1:0]    key_byte;
  logic [LIMIT_W-1:0]  read_limit;
  modport source (output valid, operation, terminal, key_byte, read_limit, input ready);
  modport sink (input valid, operation, terminal, key_byte, read_limit, output ready);
endinterface

interface vtkq_out_if;
  import vtkq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    data_byte;
  logic [TERM_W-1:0]   active_terminal;
  logic                last;
  modport source (output valid, status, data_byte, active_terminal, last, input ready);
  modport sink (input valid, status, data_byte, active_terminal, last, output ready);
endinterface

[hdl/vtkq_ctrl.sv]
module vtkq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vtkq_pkg::vtkq_sts_t sts,
  output vtkq_pkg::vtkq_cmd_t cmd
);
  import vtkq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        // a read can start its first fetch before the output slot frees
        if (sts.start_read) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_EMIT;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.pop = 1'b1;
          if (sts.stop) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/vtkq_dp.sv]
module vtkq_dp #(
  parameter int VTS         = vtkq_pkg::VTS_DEF,
  parameter int QUEUE_DEPTH = vtkq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_READ    = vtkq_pkg::MAX_READ_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  vtkq_pkg::vtkq_cmd_t             cmd,
  output vtkq_pkg::vtkq_sts_t             sts,
  input  logic [vtkq_pkg::OP_W-1:0]       in_operation,
  input  logic [vtkq_pkg::TERM_W-1:0]     in_terminal,
  input  logic [vtkq_pkg::KEY_W-1:0]      in_key_byte,
  input  logic [vtkq_pkg::LIMIT_W-1:0]    in_read_limit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vtkq_pkg::STATUS_W-1:0]   out_status,
  output logic [vtkq_pkg::KEY_W-1:0]      out_data_byte,
  output logic [vtkq_pkg::TERM_W-1:0]     out_active_terminal,
  output logic                            out_last
);
  import vtkq_pkg::*;

  localparam int Q_W    = (VTS > 1) ? $clog2(VTS) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W = $clog2(VTS * QUEUE_DEPTH);
  localparam int LIM_W  = $clog2(MAX_READ + 1);

  // item registers
  logic [OP_W-1:0]   op_r;
  logic [TERM_W-1:0] term_r;
  logic [KEY_W-1:0]  key_r;
  logic [LIM_W-1:0]  rem_r;

  logic [TERM_W-1:0] active_r, active_nxt;
  logic [PTR_W-1:0]  rp_r [VTS];
  logic [PTR_W-1:0]  rp_nxt [VTS];
  logic [PTR_W-1:0]  wp_r [VTS];
  logic [PTR_W-1:0]  wp_nxt [VTS];

  logic [KEY_W-1:0]  key_store_mem [VTS * QUEUE_DEPTH];
  logic [KEY_W-1:0]  rd_data_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [KEY_W-1:0]    out_data_r;
  logic [TERM_W-1:0]   out_active_r;
  logic                out_last_r;

  logic [TERM_W-1:0]   t_sel;
  logic                t_ok;
  logic [Q_W-1:0]      q;
  logic [PTR_W-1:0]    rp_q, wp_q, wp_inc, rp_inc;
  logic                full, empty, act_ok, push_ok, start_read, stop, out_free;
  logic [STATUS_W-1:0] eval_status;
  logic [TERM_W-1:0]   eval_active;
  logic [LIM_W-1:0]    lim_sat;
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   q_base, wr_addr, rd_addr;

  // terminal 0 names the active one
  assign t_sel = (term_r == '0) ? active_r : term_r;
  assign t_ok  = (t_sel != '0) && (t_sel <= TERM_W'(VTS));
  assign q     = t_ok ? Q_W'(t_sel - 1'b1) : '0;

  assign rp_q   = rp_r[q];
  assign wp_q   = wp_r[q];
  assign wp_inc = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_inc = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign full   = (wp_inc == rp_q);
  assign empty  = (rp_q == wp_q);
  assign act_ok = (term_r != '0) && (term_r <= TERM_W'(VTS));

  always_comb begin
    eval_status = ST_OK;
    push_ok     = 1'b0;
    start_read  = 1'b0;
    case (op_r)
      OP_PUSH: begin
        if (key_r == '0) begin
          eval_status = ST_ZERO;
        end else if (!t_ok) begin
          eval_status = ST_BADTERM;
        end else if (full) begin
          eval_status = ST_FULL;
        end else begin
          push_ok = 1'b1;
        end
      end
      OP_READ: begin
        if (rem_r == '0) begin
          eval_status = ST_OK;
        end else if (!t_ok) begin
          eval_status = ST_BADTERM;
        end else if (t_sel != active_r) begin
          eval_status = ST_NOTACTIVE;
        end else if (empty) begin
          eval_status = ST_EMPTY;
        end else begin
          start_read = 1'b1;
        end
      end
      OP_ACTIVATE: begin
        if (!act_ok) begin
          eval_status = ST_BADTERM;
        end
      end
      default: begin
        eval_status = ST_OK;
      end
    endcase
  end

  assign eval_active = (op_r == OP_ACTIVATE && act_ok) ? term_r : active_r;

  // read ends after the limit, a newline, or when the queue drains
  assign stop = (rem_r == LIM_W'(1)) || (rd_data_r == KEY_NEWLINE) || (rp_inc == wp_q);

  assign out_free = !out_valid_r || out_ready;

  assign sts.start_read = start_read;
  assign sts.stop       = stop;
  assign sts.out_free   = out_free;

  assign lim_sat = (in_read_limit > LIMIT_W'(MAX_READ)) ? LIM_W'(MAX_READ)
                                                        : LIM_W'(in_read_limit);

  always_comb begin
    active_nxt = active_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    if (cmd.finish && push_ok) begin
      wp_nxt[q] = wp_inc;
    end
    if (cmd.finish && op_r == OP_ACTIVATE && act_ok) begin
      active_nxt = term_r;
    end
    if (cmd.pop) begin
      rp_nxt[q] = rp_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= TERM_W'(1);
      rp_r        <= '{default: '0};
      wp_r        <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      rp_r     <= rp_nxt;
      wp_r     <= wp_nxt;
      if (cmd.finish || cmd.pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      term_r <= in_terminal;
      key_r  <= in_key_byte;
      rem_r  <= lim_sat;
    end else if (cmd.pop) begin
      rem_r <= rem_r - 1'b1;
    end
    if (cmd.finish) begin
      out_status_r <= eval_status;
      out_data_r   <= '0;
      out_active_r <= eval_active;
      out_last_r   <= 1'b1;
    end else if (cmd.pop) begin
      out_status_r <= ST_OK;
      out_data_r   <= rd_data_r;
      out_active_r <= active_r;
      out_last_r   <= stop;
    end
  end

  // key store: one write port, one registered read port
  assign q_base  = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH);
  assign wr_en   = cmd.finish && push_ok;
  assign wr_addr = q_base + ADDR_W'(wp_q);
  assign rd_en   = cmd.rd_issue || (cmd.pop && !stop);
  assign rd_addr = q_base + ADDR_W'(cmd.pop ? rp_inc : rp_q);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_store_mem[wr_addr] <= key_r;
    end
    if (rd_en) begin
      rd_data_r <= key_store_mem[rd_addr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_data_byte       = out_data_r;
  assign out_active_terminal = out_active_r;
  assign out_last            = out_last_r;

endmodule

[hdl/virtual_terminal_key_queues.sv]
// channel  dir  beat fields
// in_ch    in   operation, terminal, key_byte, read_limit
// out_ch   out  status, data_byte, active_terminal, last
//
// one item at a time; push, activate and every error result are accepted, then
// evaluated into the output register
// a read does one key store fetch, then pops one byte per cycle, while the output
// slot is free, off the registered read port of the key store
// reset clears the queue pointers and sets terminal 1 active; no clearing pass
// out_ready low holds the result register and the controller waits in place
module virtual_terminal_key_queues #(
  parameter int VTS         = vtkq_pkg::VTS_DEF,
  parameter int QUEUE_DEPTH = vtkq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_READ    = vtkq_pkg::MAX_READ_DEF
) (
  input logic         clk,
  input logic         rst_n,
  vtkq_in_if.sink     in_ch,
  vtkq_out_if.source  out_ch
);
  import vtkq_pkg::*;

  vtkq_cmd_t cmd;
  vtkq_sts_t sts;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  vtkq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vtkq_dp #(
    .VTS         (VTS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_READ    (MAX_READ)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_operation        (in_ch.operation),
    .in_terminal         (in_ch.terminal),
    .in_key_byte         (in_ch.key_byte),
    .in_read_limit       (in_ch.read_limit),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_status          (out_ch.status),
    .out_data_byte       (out_ch.data_byte),
    .out_active_terminal (out_ch.active_terminal),
    .out_last            (out_ch.last)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ready |=> !in_ready)
    else $error("new item accepted while one is in progress");

  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.active_terminal != '0) &&
                     (out_ch.active_terminal <= TERM_W'(VTS)))
    else $error("active terminal out of range");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_OK) |-> (out_ch.data_byte == '0))
    else $error("error result carries data");

  a_mid_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |-> (out_ch.status == ST_OK) && (out_ch.data_byte != '0))
    else $error("non-final result is not a popped byte");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import vtkq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [TERM_W-1:0]   term;
    logic [KEY_W-1:0]    key;
    logic [LIMIT_W-1:0]  lim;
    logic                typed;
    logic [STATUS_W-1:0] st;
    logic [TERM_W-1:0]   vt;
  } vt_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    data;
    logic [TERM_W-1:0]   vt;
    logic                last;
  } vt_reply_t;

  // typed rows carry their single expected reply, the rest go through the predictor
  localparam vt_cmd_t DIRECTED_OPS [25] = '{
    '{OP_READ,     4'd0,  8'h00, 7'd1,   1'b1, ST_EMPTY,     4'd1},
    '{OP_PUSH,     4'd0,  8'h00, 7'd0,   1'b1, ST_ZERO,      4'd1},
    '{OP_PUSH,     4'd15, 8'h00, 7'd127, 1'b1, ST_ZERO,      4'd1},
    '{OP_PUSH,     4'd9,  8'h41, 7'd0,   1'b1, ST_BADTERM,   4'd1},
    '{OP_PUSH,     4'd15, 8'hFF, 7'd0,   1'b1, ST_BADTERM,   4'd1},
    '{OP_PUSH,     4'd0,  8'hFF, 7'd0,   1'b1, ST_OK,        4'd1},
    '{OP_PUSH,     4'd1,  8'h0A, 7'd0,   1'b1, ST_OK,        4'd1},
    '{OP_PUSH,     4'd1,  8'h01, 7'd0,   1'b1, ST_OK,        4'd1},
    '{OP_PUSH,     4'd2,  8'h80, 7'd0,   1'b1, ST_OK,        4'd1},
    '{OP_READ,     4'd2,  8'h00, 7'd64,  1'b1, ST_NOTACTIVE, 4'd1},
    '{OP_READ,     4'd9,  8'h00, 7'd5,   1'b1, ST_BADTERM,   4'd1},
    '{OP_READ,     4'd15, 8'h00, 7'd0,   1'b1, ST_OK,        4'd1},
    '{OP_READ,     4'd0,  8'h00, 7'd127, 1'b0, ST_OK,        4'd0},
    '{OP_READ,     4'd1,  8'h00, 7'd1,   1'b0, ST_OK,        4'd0},
    '{OP_ACTIVATE, 4'd0,  8'h00, 7'd0,   1'b1, ST_BADTERM,   4'd1},
    '{OP_ACTIVATE, 4'd9,  8'h00, 7'd0,   1'b1, ST_BADTERM,   4'd1},
    '{OP_ACTIVATE, 4'd15, 8'h00, 7'd0,   1'b1, ST_BADTERM,   4'd1},
    '{OP_ACTIVATE, 4'd1,  8'h00, 7'd0,   1'b1, ST_OK,        4'd1},
    '{OP_ACTIVATE, 4'd8,  8'h00, 7'd0,   1'b1, ST_OK,        4'd8},
    '{OP_PUSH,     4'd0,  8'h55, 7'd0,   1'b1, ST_OK,        4'd8},
    '{OP_UNUSED,   4'd15, 8'hFF, 7'd127, 1'b1, ST_OK,        4'd8},
    '{OP_READ,     4'd0,  8'h00, 7'd2,   1'b0, ST_OK,        4'd0},
    '{OP_ACTIVATE, 4'd2,  8'h00, 7'd0,   1'b1, ST_OK,        4'd2},
    '{OP_READ,     4'd0,  8'h00, 7'd64,  1'b0, ST_OK,        4'd0},
    '{OP_READ,     4'd2,  8'h00, 7'd64,  1'b1, ST_EMPTY,     4'd2}
  };

  localparam int SEND_IDLE [4] = '{0, 87, 0, 12};
  localparam int RECV_STALL [4] = '{0, 0, 87, 12};

  logic clk;
  logic rst_n;

  vtkq_in_if  in_ch ();
  vtkq_out_if out_ch ();

  virtual_terminal_key_queues u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow of the terminal bank
  logic [TERM_W-1:0] cur_vt;
  logic [KEY_W-1:0]  key_ring [VTS_DEF][QUEUE_DEPTH_DEF];
  int                wr_ptr [VTS_DEF];
  int                rd_ptr [VTS_DEF];

  vt_reply_t due_replies [$];

  int idle_pct;
  int stall_pct;
  int errors;
  int n_items;
  int n_beats;
  int cycles;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped at cycle limit %0d, %0d replies still due", cycles,
               due_replies.size());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

  function automatic void queue_reply(input logic [STATUS_W-1:0] st,
                                      input logic [KEY_W-1:0] data, input logic last);
    vt_reply_t r;
    r.status = st;
    r.data   = data;
    r.vt     = cur_vt;
    r.last   = last;
    due_replies.push_back(r);
  endfunction

  // terminal 0 means the active one; 0 back means out of range
  function automatic logic [TERM_W-1:0] resolve_term(input logic [TERM_W-1:0] term);
    logic [TERM_W-1:0] t;
    t = (term == '0) ? cur_vt : term;
    return (t >= 1 && t <= VTS_DEF) ? t : '0;
  endfunction

  function automatic void predict_terminal_op(input vt_cmd_t c);
    logic [TERM_W-1:0] t;
    logic [KEY_W-1:0]  ch;
    int                q;
    int                n;
    int                nxt;
    logic              stop;
    t = resolve_term(c.term);
    q = int'(t) - 1;
    case (c.op)
      OP_PUSH: begin
        if (c.key == '0) begin
          queue_reply(ST_ZERO, '0, 1'b1);
        end else if (t == '0) begin
          queue_reply(ST_BADTERM, '0, 1'b1);
        end else begin
          nxt = (wr_ptr[q] + 1) % QUEUE_DEPTH_DEF;
          if (nxt == rd_ptr[q]) begin
            queue_reply(ST_FULL, '0, 1'b1);
          end else begin
            key_ring[q][wr_ptr[q]] = c.key;
            wr_ptr[q] = nxt;
            queue_reply(ST_OK, '0, 1'b1);
          end
        end
      end
      OP_READ: begin
        n = (c.lim > MAX_READ_DEF) ? MAX_READ_DEF : int'(c.lim);
        if (n == 0) begin
          queue_reply(ST_OK, '0, 1'b1);
        end else if (t == '0) begin
          queue_reply(ST_BADTERM, '0, 1'b1);
        end else if (t != cur_vt) begin
          queue_reply(ST_NOTACTIVE, '0, 1'b1);
        end else if (rd_ptr[q] == wr_ptr[q]) begin
          queue_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int k = 0; k < n; k++) begin
            ch = key_ring[q][rd_ptr[q]];
            rd_ptr[q] = (rd_ptr[q] + 1) % QUEUE_DEPTH_DEF;
            stop = (k + 1 >= n) || (ch == KEY_NEWLINE) || (rd_ptr[q] == wr_ptr[q]);
            queue_reply(ST_OK, ch, stop);
            if (stop) break;
          end
        end
      end
      OP_ACTIVATE: begin
        if (c.term >= 1 && c.term <= VTS_DEF) begin
          cur_vt = c.term;
          queue_reply(ST_OK, '0, 1'b1);
        end else begin
          queue_reply(ST_BADTERM, '0, 1'b1);
        end
      end
      default: queue_reply(ST_OK, '0, 1'b1);
    endcase
  endfunction

  // entered and left at a falling edge; valid stays high when beats run back to back
  task automatic send_beat(input vt_cmd_t c);
    int gap;
    vt_reply_t r;
    gap = 0;
    while (gap < 60 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= c.op;
    in_ch.terminal   <= c.term;
    in_ch.key_byte   <= c.key;
    in_ch.read_limit <= c.lim;
    do @(posedge clk); while (!in_ch.ready);
    predict_terminal_op(c);
    if (c.typed) begin
      r.status = c.st;
      r.data   = '0;
      r.vt     = c.vt;
      r.last   = 1'b1;
      void'(due_replies.pop_back());
      due_replies.push_back(r);
    end
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (due_replies.size() != 0) @(negedge clk);
  endtask

  function automatic vt_cmd_t random_cmd();
    vt_cmd_t c;
    int sel;
    int r;
    c = '0;
    c.lim = LIMIT_W'($urandom_range(0, 127));
    c.key = KEY_W'($urandom_range(0, 255));
    sel = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    if (sel < 52) begin
      c.op = OP_PUSH;
      if (r < 45)      c.term = '0;
      else if (r < 90) c.term = TERM_W'($urandom_range(1, VTS_DEF));
      else             c.term = TERM_W'($urandom_range(VTS_DEF + 1, 15));
      r = $urandom_range(0, 19);
      if (r == 0)     c.key = '0;
      else if (r < 5) c.key = KEY_NEWLINE;
      else            c.key = KEY_W'($urandom_range(1, 255));
    end else if (sel < 80) begin
      c.op = OP_READ;
      if (r < 55)      c.term = '0;
      else if (r < 80) c.term = cur_vt;
      else             c.term = TERM_W'($urandom_range(0, 15));
      r = $urandom_range(0, 99);
      if (r < 70)      c.lim = LIMIT_W'($urandom_range(1, 8));
      else if (r < 94) c.lim = LIMIT_W'($urandom_range(9, 127));
      else             c.lim = '0;
    end else if (sel < 94) begin
      c.op = OP_ACTIVATE;
      c.term = (r < 85) ? TERM_W'($urandom_range(1, VTS_DEF)) : TERM_W'($urandom_range(0, 15));
    end else begin
      c.op = OP_UNUSED;
      c.term = TERM_W'($urandom_range(0, 15));
    end
    return c;
  endfunction

  always @(posedge clk) begin
    vt_reply_t got;
    vt_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.data   = out_ch.data_byte;
      got.vt     = out_ch.active_terminal;
      got.last   = out_ch.last;
      n_beats++;
      if (due_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: status %0d data %02h vt %0d last %0b", $time,
                 got.status, got.data, got.vt, got.last);
      end else begin
        want = due_replies.pop_front();
        if (got.status !== want.status || got.data !== want.data || got.vt !== want.vt ||
            got.last !== want.last) begin
          errors++;
          // status/data/vt/last
          $display("%0t: expected %0d/%02h/%0d/%0b, got %0d/%02h/%0d/%0b",
                   $time, want.status, want.data, want.vt, want.last,
                   got.status, got.data, got.vt, got.last);
        end
      end
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.operation  = '0;
    in_ch.terminal   = '0;
    in_ch.key_byte   = '0;
    in_ch.read_limit = '0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    errors           = 0;
    n_items          = 0;
    n_beats          = 0;
    cycles           = 0;
    cur_vt           = 4'd1;
    foreach (wr_ptr[i]) begin
      wr_ptr[i] = 0;
      rd_ptr[i] = 0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_OPS[i]) send_beat(DIRECTED_OPS[i]);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = SEND_IDLE[ph];
      stall_pct = RECV_STALL[ph];
      for (int n = 0; n < 21; n++) send_beat(random_cmd());
      wait_drained();
    end

    stall_pct = 0;
    repeat (20) @(negedge clk);
    $display("sent %0d items and checked %0d reply beats over directed rows", n_items,
             n_beats);
    $display("and four random phases with sender and receiver idling mixed");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/vtkq_pkg.sv
hdl/vtkq_ifs.sv
hdl/vtkq_ctrl.sv
hdl/vtkq_dp.sv
hdl/virtual_terminal_key_queues.sv
sim/tb.sv
